// ----- design/khava_pkg.sv -----
// Shared key codes, event kinds, register indexes and step constants for the value adjuster.
`default_nettype none
package khava_pkg;

  typedef enum logic [1:0] {
    KEY_NONE = 2'd0,
    KEY_UP   = 2'd1,
    KEY_OK   = 2'd2,
    KEY_DOWN = 2'd3
  } key_t;

  typedef enum logic [1:0] {
    KIND_HELD     = 2'd0,
    KIND_PRESSED  = 2'd1,
    KIND_RELEASED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_MINIMUM = 2'd0,
    REG_MAXIMUM = 2'd1,
    REG_MEDIUM  = 2'd2,
    REG_FAST    = 2'd3
  } reg_index_t;

  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_POLL = 1'b1;

  localparam logic [7:0]  HOLD_MAX      = 8'hff;
  localparam logic [7:0]  HOLD_FOLD     = 8'hfb;
  localparam logic [7:0]  HOLD_FAST     = 8'h28;
  localparam logic [7:0]  HOLD_MEDIUM   = 8'h14;
  localparam logic [1:0]  REPEAT_MASK   = 2'b11;

  localparam logic [15:0] RESET_MINIMUM = 16'd0;
  localparam logic [15:0] RESET_MAXIMUM = 16'hffff;
  localparam logic [15:0] RESET_MEDIUM  = 16'd10;
  localparam logic [15:0] RESET_FAST    = 16'd100;

endpackage
`default_nettype wire

// ----- design/key_hold_accelerated_value_adjust.sv -----
// Keypad auto-repeat with accelerated adjustment of a clamped 16-bit value.
// The result word is registered into the output register when the input is accepted.
// Throughput: one word per cycle while out_ready holds; the output register frees itself in the cycle it is taken.
// Reset (synchronous, rst high): no key held, hold count and value zero, limits and
// steps back to 0 / 65535 / 10 / 100, and the output register empty.
`default_nettype none
module key_hold_accelerated_value_adjust
  import khava_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_write_enable,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [15:0] load_value,
  input  wire logic [2:0]  pressed_keys,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_key,
  output logic [1:0]       event_kind,
  output logic [15:0]      current_value,
  output logic             done_res,
  output logic             click
);

  // Configuration registers.
  logic [15:0] minimum_value;
  logic [15:0] maximum_value;
  logic [15:0] medium_step;
  logic [15:0] fast_step;

  // Key tracking state and the stored value.
  key_t        last_key;
  logic [7:0]  hold_count;
  logic [15:0] adjusted_value;

  key_t        last_key_next;
  logic [7:0]  hold_count_next;
  logic [15:0] adjusted_value_next;

  // Result word computed from the accepted input and the current state.
  key_t        ev_key;
  kind_t       ev_kind;
  logic        ev_done;
  logic        ev_click;

  key_t        code;
  key_t        poll_key;
  logic [7:0]  poll_count;
  logic [7:0]  folded_count;
  logic [7:0]  h;
  logic [15:0] step;
  logic        stepping;
  logic signed [17:0] room_up;
  logic signed [17:0] room_down;
  logic signed [17:0] step_s;
  logic [15:0] stepped_value;

  logic in_accept;

  // The output register is the only buffer: a new word enters whenever the
  // register is empty or its word is taken in this same cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Exactly one key down gives its code; anything else counts as no key.
  always_comb begin
    unique case (pressed_keys)
      3'b001:  code = KEY_UP;
      3'b010:  code = KEY_OK;
      3'b100:  code = KEY_DOWN;
      default: code = KEY_NONE;
    endcase
  end

  // Hold tracking. A key that changes while one is held is reported as the
  // release of the held key; the released key stays visible for that poll.
  always_comb begin
    poll_key   = last_key;
    poll_count = hold_count;
    ev_click   = 1'b0;
    if (hold_count != 8'd0 && last_key != KEY_NONE) begin
      if (code == last_key) begin
        if (hold_count != HOLD_MAX) begin
          poll_count = hold_count + 8'd1;
        end
      end else begin
        poll_count = 8'd0;
      end
    end else if (code != KEY_NONE) begin
      poll_key   = code;
      poll_count = 8'd1;
      ev_click   = 1'b1;
    end else begin
      poll_key   = KEY_NONE;
      poll_count = 8'd0;
    end
  end

  // Event kind follows the updated hold count.
  always_comb begin
    ev_key  = poll_key;
    ev_kind = KIND_HELD;
    if (poll_key != KEY_NONE) begin
      if (poll_count == 8'd0) begin
        ev_kind = KIND_RELEASED;
      end else if (poll_count == 8'd1) begin
        ev_kind = KIND_PRESSED;
      end
    end
    ev_done = (poll_key == KEY_OK) && (poll_count == 8'd0);
  end

  // Accelerated step: the first press steps by one, then every fourth poll
  // repeats with a step that grows with the hold length. A saturated count
  // folds back so the repeat cadence keeps going.
  always_comb begin
    stepping     = (poll_key == KEY_UP || poll_key == KEY_DOWN) && (poll_count != 8'd0);
    folded_count = (poll_count == HOLD_MAX) ? HOLD_FOLD : poll_count;
    h            = folded_count - 8'd1;
    if ((h[1:0] & REPEAT_MASK) != 2'b00) begin
      step = 16'd0;
    end else if (h >= HOLD_FAST) begin
      step = fast_step;
    end else if (h >= HOLD_MEDIUM) begin
      step = medium_step;
    end else begin
      step = 16'd1;
    end
  end

  // Clamp against signed distances to the limits, so a value outside a limit
  // snaps onto it on any up or down poll that steps toward that limit, even with a zero step.
  always_comb begin
    step_s    = $signed({2'b00, step});
    room_up   = $signed({2'b00, maximum_value}) - $signed({2'b00, adjusted_value});
    room_down = $signed({2'b00, adjusted_value}) - $signed({2'b00, minimum_value});
    if (poll_key == KEY_UP) begin
      stepped_value = (room_up > step_s) ? (adjusted_value + step) : maximum_value;
    end else begin
      stepped_value = (room_down > step_s) ? (adjusted_value - step) : minimum_value;
    end
  end

  // Next state for a poll or a load.
  always_comb begin
    last_key_next       = last_key;
    hold_count_next     = hold_count;
    adjusted_value_next = adjusted_value;
    if (op == OP_LOAD) begin
      adjusted_value_next = load_value;
    end else begin
      last_key_next   = poll_key;
      hold_count_next = stepping ? folded_count : poll_count;
      if (stepping) begin
        adjusted_value_next = stepped_value;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      minimum_value <= RESET_MINIMUM;
      maximum_value <= RESET_MAXIMUM;
      medium_step   <= RESET_MEDIUM;
      fast_step     <= RESET_FAST;
    end else if (cfg_write_enable) begin
      unique case (reg_index_t'(cfg_index))
        REG_MINIMUM: minimum_value <= cfg_data;
        REG_MAXIMUM: maximum_value <= cfg_data;
        REG_MEDIUM:  medium_step   <= cfg_data;
        REG_FAST:    fast_step     <= cfg_data;
      endcase
    end
  end

  // Key state and value update on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_key       <= KEY_NONE;
      hold_count     <= 8'd0;
      adjusted_value <= 16'd0;
    end else if (in_accept) begin
      last_key       <= last_key_next;
      hold_count     <= hold_count_next;
      adjusted_value <= adjusted_value_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload; a load reports no key activity.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      current_value <= adjusted_value_next;
      if (op == OP_LOAD) begin
        event_key  <= KEY_NONE;
        event_kind <= KIND_HELD;
        done_res   <= 1'b0;
        click      <= 1'b0;
      end else begin
        event_key  <= ev_key;
        event_kind <= ev_kind;
        done_res   <= ev_done;
        click      <= ev_click;
      end
    end
  end

endmodule
`default_nettype wire
